// ===== rtl/shp_pkg.sv =====
// Package for the 3x3 sharpening stream block: field widths, reset values and
// the window state type shared by the top level and the kernel.
// Depends on nothing.
package shp_pkg;

   localparam int PIX_W     = 8;
   localparam int DATA_W    = 32;
   localparam int MASK_W    = 4;
   localparam int BUS_LANES = DATA_W / PIX_W;
   localparam int COL_W     = 12;
   localparam int CNT_W     = COL_W + 1;

   localparam logic [COL_W-1:0] ROW_LEN_RESET = 12'd2048;

   typedef logic [PIX_W-1:0] pix_type;

   // Pixels of the previous column (top, middle, bottom) and the middle pixel
   // two columns back.
   typedef struct packed {
      pix_type top;
      pix_type mid;
      pix_type bot;
      pix_type mid2;
   } win_type;

endpackage

// ===== rtl/shp_req_if.sv =====
// Input channel of the sharpening block: valid/ready plus the pixel beat.
// Depends on shp_pkg.
interface shp_req_if;
   logic                         valid;
   logic                         ready;
   logic [shp_pkg::DATA_W-1:0]   pixel_data;
   logic [shp_pkg::MASK_W-1:0]   byte_keep;
   logic [shp_pkg::MASK_W-1:0]   byte_strobe;
   logic                         frame_last;

   modport source (output valid, pixel_data, byte_keep, byte_strobe, frame_last,
                   input ready);
   modport sink   (input valid, pixel_data, byte_keep, byte_strobe, frame_last,
                   output ready);
endinterface

// ===== rtl/shp_rsp_if.sv =====
// Result channel of the sharpening block: valid/ready plus the sharpened beat.
// Depends on shp_pkg.
interface shp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [shp_pkg::DATA_W-1:0]   sharp_data;
   logic [shp_pkg::MASK_W-1:0]   out_keep;
   logic [shp_pkg::MASK_W-1:0]   out_strobe;
   logic                         out_last;
   logic                         width_error;

   modport source (output valid, sharp_data, out_keep, out_strobe, out_last,
                   width_error, input ready);
   modport sink   (input valid, sharp_data, out_keep, out_strobe, out_last,
                   width_error, output ready);
endinterface

// ===== rtl/shp_line_store.sv =====
// Two-line pixel store: one row per beat holds the lanes of line r-1 (low half)
// and line r-2 (high half). Registered read with write bypass, zero sweep after
// reset. Depends on nothing outside this file.
module shp_line_store #(
   parameter int DEPTH  = 512,
   parameter int AW     = 9,
   parameter int WORD_W = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [WORD_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [WORD_W-1:0] wr_data,
   output logic              clear_busy
);

   localparam logic [AW-1:0] LAST_ROW = AW'(DEPTH - 1);

   logic [WORD_W-1:0] mem_ram [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;
   logic              clr_busy_ff;
   logic [AW-1:0]     clr_addr_ff;
   logic              port_wr_en;
   logic [AW-1:0]     port_wr_addr;
   logic [WORD_W-1:0] port_wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == LAST_ROW) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      if (clr_busy_ff) begin
         port_wr_en   = 1'b1;
         port_wr_addr = clr_addr_ff;
         port_wr_data = '0;
      end else begin
         port_wr_en   = wr_en;
         port_wr_addr = wr_addr;
         port_wr_data = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (port_wr_en) begin
         mem_ram[port_wr_addr] <= port_wr_data;
      end
   end

   // A row written at the same edge as it is read is forwarded.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (port_wr_en && (port_wr_addr == rd_addr)) begin
            rd_data_ff <= port_wr_data;
         end else begin
            rd_data_ff <= mem_ram[rd_addr];
         end
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clr_busy_ff;

endmodule

// ===== rtl/shp_kernel.sv =====
// Sharpening kernel for one beat: chains the window across the lanes and
// computes the clamped 5-point Laplacian for every lane. Depends on shp_pkg.
module shp_kernel #(
   parameter int PIXELS_PER_BEAT = 4
) (
   input  shp_pkg::win_type                                   win_cur,
   input  logic                                               line_start,
   input  logic [PIXELS_PER_BEAT-1:0][shp_pkg::PIX_W-1:0]     lane_top,
   input  logic [PIXELS_PER_BEAT-1:0][shp_pkg::PIX_W-1:0]     lane_mid,
   input  logic [PIXELS_PER_BEAT-1:0][shp_pkg::PIX_W-1:0]     lane_bot,
   output logic [PIXELS_PER_BEAT-1:0][shp_pkg::PIX_W-1:0]     lane_res,
   output shp_pkg::win_type                                   win_next
);

   localparam int SUM_W = 12;

   shp_pkg::pix_type ext_top [PIXELS_PER_BEAT+1];
   shp_pkg::pix_type ext_bot [PIXELS_PER_BEAT+1];
   shp_pkg::pix_type ext_mid [PIXELS_PER_BEAT+2];
   logic [SUM_W-1:0] acc     [PIXELS_PER_BEAT];

   // At the start of a line, columns left of the image read as zero.
   always_comb begin
      ext_top[0] = line_start ? '0 : win_cur.top;
      ext_bot[0] = line_start ? '0 : win_cur.bot;
      ext_mid[0] = line_start ? '0 : win_cur.mid2;
      ext_mid[1] = line_start ? '0 : win_cur.mid;
      for (int p = 0; p < PIXELS_PER_BEAT; p++) begin
         ext_top[p+1] = lane_top[p];
         ext_bot[p+1] = lane_bot[p];
         ext_mid[p+2] = lane_mid[p];
      end
   end

   // The sum spans -1020..1275, so 12 bits in two's complement never wrap.
   always_comb begin
      for (int p = 0; p < PIXELS_PER_BEAT; p++) begin
         acc[p] = ({4'h0, ext_mid[p+1]} << 2) + {4'h0, ext_mid[p+1]}
                - {4'h0, ext_top[p]} - {4'h0, ext_bot[p]}
                - {4'h0, ext_mid[p]} - {4'h0, ext_mid[p+2]};
         if (acc[p][SUM_W-1]) begin
            lane_res[p] = '0;
         end else if (|acc[p][SUM_W-2:shp_pkg::PIX_W]) begin
            lane_res[p] = '1;
         end else begin
            lane_res[p] = acc[p][shp_pkg::PIX_W-1:0];
         end
      end
   end

   always_comb begin
      win_next.top  = ext_top[PIXELS_PER_BEAT];
      win_next.mid  = ext_mid[PIXELS_PER_BEAT+1];
      win_next.bot  = ext_bot[PIXELS_PER_BEAT];
      win_next.mid2 = ext_mid[PIXELS_PER_BEAT];
   end

endmodule

// ===== rtl/sharpen_3x3_stream.sv =====
// Top level of the 3x3 Laplacian sharpening stream block.
// Depends on shp_pkg, shp_req_if, shp_rsp_if, shp_line_store and shp_kernel.
//
// Usage:
//   req_chan carries one transaction per beat of PIXELS_PER_BEAT packed 8-bit
//   pixels in raster order, lowest byte first, with keep, strobe and last.
//   rsp_chan returns exactly one transaction per input transaction, in order,
//   holding the sharpened pixel of (r-1, c-1) for each input pixel at (r, c),
//   clamped to 0..255. Keep, strobe and last are copied through, and
//   width_error is set when the row length exceeds MAX_WIDTH (it is then clamped).
//   csr_wr_en/csr_wr_data write the row length; write it only while the block is idle.
// Timing:
//   An accepted transaction passes from the compute stage register into the
//   result register, where it is held until the receiver takes it. One
//   transaction per cycle is sustained while the receiver takes results: the
//   line store row is read at the accepting edge and written back when the
//   beat leaves the compute stage, with a bypass for back-to-back hits on one row.
// Reset and stalls:
//   After reset the line store is swept to zero, one row per cycle, over all
//   ceil(MAX_WIDTH / PIXELS_PER_BEAT) rows (512 by default); req_chan.ready is
//   low while the sweep runs. The store keeps its contents across frames. When the
//   receiver stalls, the result register holds, the compute stage fills, and
//   req_chan.ready drops until the result is taken.
module sharpen_3x3_stream #(
   parameter int PIXELS_PER_BEAT = 4,
   parameter int MAX_WIDTH       = 2048
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [shp_pkg::COL_W-1:0]   csr_wr_data,
   shp_req_if.sink                     req_chan,
   shp_rsp_if.source                   rsp_chan
);

   localparam int PW     = shp_pkg::PIX_W;
   localparam int CW     = shp_pkg::CNT_W;
   localparam int DEPTH  = (MAX_WIDTH + PIXELS_PER_BEAT - 1) / PIXELS_PER_BEAT;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WORD_W = 2 * PIXELS_PER_BEAT * PW;
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_WIDTH);
   localparam logic [CW-1:0] STEP    = CW'(PIXELS_PER_BEAT);

   // Configuration and position state.
   logic [shp_pkg::COL_W-1:0] row_len_ff;
   logic [shp_pkg::COL_W-1:0] col_ff, col_in;
   logic [AW-1:0]             row_ff, row_in;

   // Compute stage (input register).
   logic                                  s1_valid_ff, s1_valid_in;
   logic [AW-1:0]                         s1_row_ff;
   logic [PIXELS_PER_BEAT-1:0][PW-1:0]    s1_pix_ff;
   logic [PIXELS_PER_BEAT-1:0]            s1_lane_ok_ff;
   logic                                  s1_line_start_ff;
   logic [shp_pkg::MASK_W-1:0]            s1_keep_ff, s1_strobe_ff;
   logic                                  s1_last_ff, s1_err_ff;

   // Result register.
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [shp_pkg::DATA_W-1:0]            rsp_data_ff;
   logic [shp_pkg::MASK_W-1:0]            rsp_keep_ff, rsp_strobe_ff;
   logic                                  rsp_last_ff, rsp_err_ff;

   shp_pkg::win_type                      win_ff, win_next;

   logic                                  clear_busy;
   logic                                  accept, s2_load, s1_free;
   logic [CW-1:0]                         width_eff, col_sum;
   logic                                  width_err, wrap;
   logic [PIXELS_PER_BEAT-1:0]            lane_ok;
   logic [PIXELS_PER_BEAT-1:0][PW-1:0]    in_pix;
   logic [WORD_W-1:0]                     rd_word, wr_word;
   logic [PIXELS_PER_BEAT-1:0][PW-1:0]    lane_top, lane_mid, lane_res;
   logic [shp_pkg::BUS_LANES-1:0][PW-1:0] sharp_bus;

   // Handshake: the compute stage moves on whenever the result register is
   // empty or being emptied, and a new transaction enters behind it.
   assign s2_load          = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign s1_free          = !s1_valid_ff || s2_load;
   assign req_chan.ready   = !clear_busy && s1_free;
   assign accept           = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s2_load) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s2_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Width clamp and column advance. The column is always a multiple of the
   // beat size, so the store row simply counts beats alongside it.
   always_comb begin
      width_err = {1'b0, row_len_ff} > MAX_CNT;
      width_eff = width_err ? MAX_CNT : {1'b0, row_len_ff};
      col_sum   = {1'b0, col_ff} + STEP;
      wrap      = (col_sum >= width_eff) || req_chan.frame_last;
      col_in    = wrap ? '0 : col_sum[shp_pkg::COL_W-1:0];
      row_in    = wrap ? '0 : row_ff + 1'b1;
      for (int p = 0; p < PIXELS_PER_BEAT; p++) begin
         lane_ok[p] = ({1'b0, col_ff} + CW'(p)) < MAX_CNT;
      end
   end

   // Lanes beyond the 32-bit bus carry zero pixels.
   for (genvar p = 0; p < PIXELS_PER_BEAT; p++) begin : g_in_lane
      if (p < shp_pkg::BUS_LANES) begin : g_bus
         assign in_pix[p] = req_chan.pixel_data[p*PW +: PW];
      end else begin : g_pad
         assign in_pix[p] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_len_ff <= shp_pkg::ROW_LEN_RESET;
      end else if (csr_wr_en) begin
         row_len_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         win_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (s2_load) begin
            win_ff <= win_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_row_ff        <= row_ff;
         s1_pix_ff        <= in_pix;
         s1_lane_ok_ff    <= lane_ok;
         s1_line_start_ff <= (col_ff == '0);
         s1_keep_ff       <= req_chan.byte_keep;
         s1_strobe_ff     <= req_chan.byte_strobe;
         s1_last_ff       <= req_chan.frame_last;
         s1_err_ff        <= width_err;
      end
   end

   shp_line_store #(
      .DEPTH  (DEPTH),
      .AW     (AW),
      .WORD_W (WORD_W)
   ) u_line_store (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (accept),
      .rd_addr    (row_ff),
      .rd_data    (rd_word),
      .wr_en      (s2_load),
      .wr_addr    (s1_row_ff),
      .wr_data    (wr_word),
      .clear_busy (clear_busy)
   );

   // Lanes at or past the maximum width read zero from the store. The written
   // row shifts line r-1 up to r-2 and puts the new pixels in as line r-1.
   always_comb begin
      for (int p = 0; p < PIXELS_PER_BEAT; p++) begin
         lane_mid[p] = s1_lane_ok_ff[p] ? rd_word[p*PW +: PW] : '0;
         lane_top[p] = s1_lane_ok_ff[p] ? rd_word[(PIXELS_PER_BEAT+p)*PW +: PW] : '0;
      end
      wr_word = {lane_mid, s1_pix_ff};
   end

   shp_kernel #(
      .PIXELS_PER_BEAT (PIXELS_PER_BEAT)
   ) u_kernel (
      .win_cur    (win_ff),
      .line_start (s1_line_start_ff),
      .lane_top   (lane_top),
      .lane_mid   (lane_mid),
      .lane_bot   (s1_pix_ff),
      .lane_res   (lane_res),
      .win_next   (win_next)
   );

   for (genvar p = 0; p < shp_pkg::BUS_LANES; p++) begin : g_out_lane
      if (p < PIXELS_PER_BEAT) begin : g_used
         assign sharp_bus[p] = lane_res[p];
      end else begin : g_idle
         assign sharp_bus[p] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         rsp_data_ff   <= sharp_bus;
         rsp_keep_ff   <= s1_keep_ff;
         rsp_strobe_ff <= s1_strobe_ff;
         rsp_last_ff   <= s1_last_ff;
         rsp_err_ff    <= s1_err_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.sharp_data  = rsp_data_ff;
   assign rsp_chan.out_keep    = rsp_keep_ff;
   assign rsp_chan.out_strobe  = rsp_strobe_ff;
   assign rsp_chan.out_last    = rsp_last_ff;
   assign rsp_chan.width_error = rsp_err_ff;

endmodule

// ===== rtl/shp_checker.sv =====
// Port-level checker for the sharpening stream block, bound to its top level.
// Depends on shp_pkg and sharpen_3x3_stream.
module shp_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [shp_pkg::DATA_W-1:0] rsp_sharp_data
);

   logic [2:0] pend_ff;

   // Transactions accepted but not yet delivered.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_ff + {2'b00, req_valid && req_ready}
                            - {2'b00, rsp_valid && rsp_ready};
      end
   end

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_sweep_blocks_req: assert property (@(posedge clock) $fell(reset) |-> !req_ready)
      else $error("input ready during the line store sweep");

   a_no_invented_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pend_ff != 3'd0))
      else $error("result offered with no transaction outstanding");

   a_stall_holds_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_sharp_data))
      else $error("result data changed while stalled");

endmodule

bind sharpen_3x3_stream shp_checker u_shp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_sharp_data (rsp_chan.sharp_data)
);
